// ===== sv/transaction_intrinsic_gas_core_defines.svh =====
// ----------------------------------------------------------------------------
// Intrinsic gas core assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRANSACTION_INTRINSIC_GAS_CORE_DEFINES_SVH
`define TRANSACTION_INTRINSIC_GAS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle, outside of reset.
`define TIG_ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle, with reset cycles included.
`define TIG_ASSERT_ALWAYS(label, clk_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/tig_pkg.sv =====
// ----------------------------------------------------------------------------
// Intrinsic gas package
// Item types, gas constants, widths and the saturation helper.
// ----------------------------------------------------------------------------
package tig_pkg;

  localparam int COUNT_BITS = 32;
  localparam int KEY_BITS   = COUNT_BITS + 16;
  localparam int AUTH_BITS  = 16;
  localparam int GAS_BITS   = 64;
  localparam int SUM_BITS   = (KEY_BITS + 15 > GAS_BITS + 1) ? KEY_BITS + 15 : GAS_BITS + 1;

  localparam int ZERO_W  = COUNT_BITS + 2;
  localparam int NZ_W    = COUNT_BITS + 7;
  localparam int ENTRY_W = COUNT_BITS + 12;
  localparam int KEYC_W  = KEY_BITS + 11;
  localparam int AUTHC_W = AUTH_BITS + 15;
  localparam int SIZE_W  = COUNT_BITS + 2;
  localparam int WORD_W  = SIZE_W - 4;
  localparam int TOK_W   = COUNT_BITS + 3;
  localparam int CREATE_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int BASE_GAS    = 21000;
  localparam int CREATE_GAS  = 32000;
  localparam int ENTRY_GAS   = 2400;
  localparam int KEY_GAS     = 1900;
  localparam int AUTH_GAS    = 25000;
  localparam int NZ_GAS_OLD  = 68;
  localparam int NZ_GAS_NEW  = 16;
  localparam int TOKEN_GAS   = 10;
  localparam int WORD_ROUND  = 31;

  localparam logic [2:0] ERA_FRONTIER = 3'd0;
  localparam logic [2:0] ERA_HOMESTEAD = 3'd1;
  localparam logic [2:0] ERA_ISTANBUL = 3'd2;
  localparam logic [2:0] ERA_SHANGHAI = 3'd3;
  localparam logic [2:0] ERA_PRAGUE = 3'd4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_ENTRY = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic                creates;
    logic [15:0]         auth_count;
    logic [GAS_BITS-1:0] gas_cap;
    logic [7:0]          data_byte;
    logic [15:0]         key_count;
  } item_t;

  typedef struct packed {
    logic [GAS_BITS-1:0] intr_gas;
    logic [GAS_BITS-1:0] floor_cost;
    logic [GAS_BITS-1:0] required_gas;
    logic                gas_ok;
  } result_t;

  typedef struct packed {
    cmd_t                 op;
    logic                 creates;
    logic [AUTH_BITS-1:0] auth_count;
    logic [GAS_BITS-1:0]  gas_cap;
    logic                 zero_byte;
    logic [15:0]          key_count;
  } qentry_t;

  typedef struct packed {
    logic [ZERO_W-1:0]   zero_cost;
    logic [NZ_W-1:0]     nz_cost;
    logic [ENTRY_W-1:0]  entry_cost;
    logic [KEYC_W-1:0]   key_cost;
    logic [AUTHC_W-1:0]  auth_cost;
    logic [CREATE_W-1:0] create_cost;
    logic [WORD_W-1:0]   word_cost;
    logic [TOK_W-1:0]    tokens;
    logic                prague;
    logic [GAS_BITS-1:0] limit;
  } cost_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] part_a;
    logic [SUM_BITS-1:0] part_b;
    logic [SUM_BITS-1:0] part_c;
    logic [SUM_BITS-1:0] floor_raw;
    logic [GAS_BITS-1:0] limit;
  } partial_t;

  typedef struct packed {
    logic [GAS_BITS-1:0] gas;
    logic [GAS_BITS-1:0] floor_cost;
    logic [GAS_BITS-1:0] limit;
  } total_t;

  function automatic logic [GAS_BITS-1:0] sat_gas(input logic [SUM_BITS-1:0] v);
    logic [GAS_BITS-1:0] r;
    if (v[SUM_BITS-1:GAS_BITS] != '0) begin
      r = '1;
    end else begin
      r = v[GAS_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/tig_front.sv =====
// ----------------------------------------------------------------------------
// Intrinsic gas front end
// Accepts input items, decodes the command and queues a classified entry.
// ----------------------------------------------------------------------------
module tig_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tig_pkg::item_t    item,
  output logic              push,
  output tig_pkg::qentry_t  push_entry,
  input  logic              queue_full
);

  logic             held_valid;
  logic             held_valid_next;
  tig_pkg::qentry_t held;
  tig_pkg::qentry_t decoded;
  logic             accept;

  assign push       = held_valid && !queue_full;
  assign item_stall = held_valid && queue_full;
  assign accept     = item_valid && !item_stall;
  assign push_entry = held;

  always_comb begin
    decoded.op         = tig_pkg::cmd_t'(item.cmd);
    decoded.creates    = item.creates;
    decoded.auth_count = item.auth_count;
    decoded.gas_cap    = item.gas_cap;
    decoded.zero_byte  = (item.data_byte == 8'd0);
    decoded.key_count  = item.key_count;
  end

  always_comb begin
    held_valid_next = held_valid;
    if (accept) begin
      held_valid_next = 1'b1;
    end else if (push) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= decoded;
    end
  end

endmodule

// ===== sv/tig_queue.sv =====
// ----------------------------------------------------------------------------
// Intrinsic gas item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module tig_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tig_pkg::qentry_t push_entry,
  output logic             full,
  output logic             head_valid,
  output tig_pkg::qentry_t head,
  input  logic             pop
);

  tig_pkg::qentry_t              slots [tig_pkg::QUEUE_DEPTH];
  logic [tig_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [tig_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [tig_pkg::QUEUE_AW:0]    fill;
  logic [tig_pkg::QUEUE_AW:0]    fill_next;

  assign full       = (fill == (tig_pkg::QUEUE_AW + 1)'(tig_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 1'b1;
    end else if (pop && !push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== sv/tig_back.sv =====
// ----------------------------------------------------------------------------
// Intrinsic gas back end
// Updates the transaction counters and computes the gas totals on end items.
// ----------------------------------------------------------------------------
module tig_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        fork_rules,
  input  logic              head_valid,
  input  tig_pkg::qentry_t  head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output tig_pkg::result_t  result
);

  logic [tig_pkg::COUNT_BITS-1:0] zero_count;
  logic [tig_pkg::COUNT_BITS-1:0] nonzero_bytes;
  logic [tig_pkg::COUNT_BITS-1:0] entry_total;
  logic [tig_pkg::KEY_BITS-1:0]   key_total;
  logic                           create_flag;
  logic [tig_pkg::AUTH_BITS-1:0]  auth_total;
  logic [tig_pkg::GAS_BITS-1:0]   limit_held;

  logic [tig_pkg::COUNT_BITS-1:0] zero_count_next;
  logic [tig_pkg::COUNT_BITS-1:0] nonzero_bytes_next;
  logic [tig_pkg::COUNT_BITS-1:0] entry_total_next;
  logic [tig_pkg::KEY_BITS-1:0]   key_total_next;
  logic                           create_flag_next;
  logic [tig_pkg::AUTH_BITS-1:0]  auth_total_next;
  logic [tig_pkg::GAS_BITS-1:0]   limit_held_next;
  logic [tig_pkg::KEY_BITS:0]     key_sum;

  logic                advance;
  logic                cost_valid;
  logic                part_valid;
  logic                total_valid;
  tig_pkg::cost_t      cost;
  tig_pkg::cost_t      cost_next;
  tig_pkg::partial_t   part;
  tig_pkg::partial_t   part_next;
  tig_pkg::total_t     total;
  tig_pkg::total_t     total_next;
  tig_pkg::result_t    result_next;
  logic [tig_pkg::SIZE_W-1:0] size_rounded;
  logic [tig_pkg::SUM_BITS-1:0] gas_sum;

  assign advance = !(result_valid && result_stall);
  assign pop     = head_valid && advance;

  always_comb begin
    zero_count_next    = zero_count;
    nonzero_bytes_next = nonzero_bytes;
    entry_total_next   = entry_total;
    key_total_next     = key_total;
    create_flag_next   = create_flag;
    auth_total_next    = auth_total;
    limit_held_next    = limit_held;
    key_sum = {1'b0, key_total} + (tig_pkg::KEY_BITS + 1)'(head.key_count);
    unique case (head.op)
      tig_pkg::CMD_START: begin
        zero_count_next    = '0;
        nonzero_bytes_next = '0;
        entry_total_next   = '0;
        key_total_next     = '0;
        create_flag_next   = head.creates;
        auth_total_next    = head.auth_count;
        limit_held_next    = head.gas_cap;
      end
      tig_pkg::CMD_BYTE: begin
        if (head.zero_byte) begin
          if (!(&zero_count)) begin
            zero_count_next = zero_count + 1'b1;
          end
        end else if (!(&nonzero_bytes)) begin
          nonzero_bytes_next = nonzero_bytes + 1'b1;
        end
      end
      tig_pkg::CMD_ENTRY: begin
        if (!(&entry_total)) begin
          entry_total_next = entry_total + 1'b1;
        end
        key_total_next = key_sum[tig_pkg::KEY_BITS] ? '1 : key_sum[tig_pkg::KEY_BITS-1:0];
      end
      tig_pkg::CMD_END: begin
      end
    endcase
  end

  always_comb begin
    size_rounded = tig_pkg::SIZE_W'(zero_count) + tig_pkg::SIZE_W'(nonzero_bytes)
                 + tig_pkg::SIZE_W'(tig_pkg::WORD_ROUND);
    cost_next.zero_cost = {zero_count, 2'b00};
    if (fork_rules >= tig_pkg::ERA_ISTANBUL) begin
      cost_next.nz_cost = tig_pkg::NZ_W'(nonzero_bytes)
                        * tig_pkg::NZ_W'(tig_pkg::NZ_GAS_NEW);
    end else begin
      cost_next.nz_cost = tig_pkg::NZ_W'(nonzero_bytes)
                        * tig_pkg::NZ_W'(tig_pkg::NZ_GAS_OLD);
    end
    cost_next.entry_cost = tig_pkg::ENTRY_W'(entry_total)
                         * tig_pkg::ENTRY_W'(tig_pkg::ENTRY_GAS);
    cost_next.key_cost = tig_pkg::KEYC_W'(key_total) * tig_pkg::KEYC_W'(tig_pkg::KEY_GAS);
    cost_next.auth_cost = tig_pkg::AUTHC_W'(auth_total)
                        * tig_pkg::AUTHC_W'(tig_pkg::AUTH_GAS);
    if (create_flag && (fork_rules >= tig_pkg::ERA_HOMESTEAD)) begin
      cost_next.create_cost = tig_pkg::CREATE_W'(tig_pkg::CREATE_GAS);
    end else begin
      cost_next.create_cost = '0;
    end
    if (create_flag && (fork_rules >= tig_pkg::ERA_SHANGHAI)) begin
      cost_next.word_cost = {size_rounded[tig_pkg::SIZE_W-1:5], 1'b0};
    end else begin
      cost_next.word_cost = '0;
    end
    cost_next.tokens = tig_pkg::TOK_W'(zero_count) + tig_pkg::TOK_W'({nonzero_bytes, 2'b00});
    cost_next.prague = (fork_rules >= tig_pkg::ERA_PRAGUE);
    cost_next.limit  = limit_held;
  end

  always_comb begin
    part_next.part_a = tig_pkg::SUM_BITS'(tig_pkg::BASE_GAS)
                     + tig_pkg::SUM_BITS'(cost.create_cost)
                     + tig_pkg::SUM_BITS'(cost.word_cost)
                     + tig_pkg::SUM_BITS'(cost.zero_cost);
    part_next.part_b = tig_pkg::SUM_BITS'(cost.nz_cost) + tig_pkg::SUM_BITS'(cost.entry_cost);
    part_next.part_c = tig_pkg::SUM_BITS'(cost.key_cost) + tig_pkg::SUM_BITS'(cost.auth_cost);
    if (cost.prague) begin
      part_next.floor_raw = tig_pkg::SUM_BITS'(cost.tokens)
                          * tig_pkg::SUM_BITS'(tig_pkg::TOKEN_GAS)
                          + tig_pkg::SUM_BITS'(tig_pkg::BASE_GAS);
    end else begin
      part_next.floor_raw = '0;
    end
    part_next.limit = cost.limit;
  end

  always_comb begin
    gas_sum = part.part_a + part.part_b + part.part_c;
    total_next.gas        = tig_pkg::sat_gas(gas_sum);
    total_next.floor_cost = tig_pkg::sat_gas(part.floor_raw);
    total_next.limit      = part.limit;
  end

  always_comb begin
    result_next.intr_gas     = total.gas;
    result_next.floor_cost   = total.floor_cost;
    result_next.required_gas = (total.gas > total.floor_cost) ? total.gas : total.floor_cost;
    result_next.gas_ok       = (total.limit >= result_next.required_gas);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_count    <= '0;
      nonzero_bytes <= '0;
      entry_total   <= '0;
      key_total     <= '0;
      create_flag   <= 1'b0;
      auth_total    <= '0;
      limit_held    <= '0;
      cost_valid    <= 1'b0;
      part_valid    <= 1'b0;
      total_valid   <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (pop) begin
        zero_count    <= zero_count_next;
        nonzero_bytes <= nonzero_bytes_next;
        entry_total   <= entry_total_next;
        key_total     <= key_total_next;
        create_flag   <= create_flag_next;
        auth_total    <= auth_total_next;
        limit_held    <= limit_held_next;
      end
      if (advance) begin
        cost_valid   <= pop && (head.op == tig_pkg::CMD_END);
        part_valid   <= cost_valid;
        total_valid  <= part_valid;
        result_valid <= total_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cost   <= cost_next;
      part   <= part_next;
      total  <= total_next;
      result <= result_next;
    end
  end

endmodule

// ===== sv/transaction_intrinsic_gas_core.sv =====
// ----------------------------------------------------------------------------
// Transaction intrinsic gas core
// Top level: fork register, front end, item queue and back end.
// ----------------------------------------------------------------------------
// Items enter on item/item_valid and are taken when item_stall is low. A start
// item opens a transaction, byte and access-list items update the counters,
// and an end item produces one result on result/result_valid, which the
// receiver takes when result_stall is low. Other items produce no result.
// The block takes one item per cycle while item_stall is low. When nothing
// stalls, an end item's result passes in order through the front register,
// the queue and the cost, partial-sum and total stages, after which it sits
// in the output register of the back end. A stalled result holds the back
// end, while the four-entry queue keeps taking items until it fills, then
// item_stall rises.
// The fork register is written through cfg_valid and cfg_data; cfg_ready is
// always high. Reset empties the pipeline, clears the counters and sets the
// fork register to the prague rules.
// ----------------------------------------------------------------------------
`include "transaction_intrinsic_gas_core_defines.svh"

module transaction_intrinsic_gas_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tig_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output tig_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_data
);

  logic [2:0]       fork_code;
  logic             push;
  tig_pkg::qentry_t push_entry;
  logic             queue_full;
  logic             head_valid;
  tig_pkg::qentry_t head;
  logic             pop;

  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fork_code <= tig_pkg::ERA_PRAGUE;
    end else if (cfg_valid && cfg_ready) begin
      fork_code <= cfg_data;
    end
  end

  tig_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  tig_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tig_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fork_rules   (fork_code),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `TIG_ASSERT_IMPLIES(a_req_covers_gas, clk, rst, result_valid, result.required_gas >= result.intr_gas, "required gas below intrinsic gas")
  `TIG_ASSERT_IMPLIES(a_req_covers_floor, clk, rst, result_valid, result.required_gas >= result.floor_cost, "required gas below floor gas")
  `TIG_ASSERT_IMPLIES(a_gas_has_base, clk, rst, result_valid, result.intr_gas >= 64'(tig_pkg::BASE_GAS), "intrinsic gas below base cost")
  `TIG_ASSERT_ALWAYS(a_reset_empties, clk, $past(rst), !result_valid, "result valid right after reset")

endmodule
